### src/assert_macros.svh
// Assertion macros shared by the running statistics RTL.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srs: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srs: next-cycle check failed");

`endif

### src/srs_pkg.sv
// Types and fixed constants of the running statistics unit.
// Used by every module of the block; depends on nothing.
package srs_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 32;
	localparam int SQ_W       = 48;
	localparam int CNT_OUT_W  = 17;
	localparam int MEAN_W     = 20;
	localparam int STD_W      = 19;
	localparam int MEAN_FRAC  = 4;
	localparam int MUL_STEPS  = 32;
	localparam int MEAN_STEPS = SUM_W + MEAN_FRAC;
	localparam int SQRT_SHIFT = 8;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                restart;
	} in_word_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] sample_count;
		logic [MEAN_W-1:0]    mean_q4;
		logic [STD_W-1:0]     std_dev_q4;
		logic [SAMPLE_W-1:0]  minimum;
		logic [SAMPLE_W-1:0]  maximum;
		logic [SAMPLE_W-1:0]  spread;
		logic                 full_res;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic step;
	} unit_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_PREP,
		ST_ROOT,
		ST_FIN
	} state_t;

endpackage

### src/srs_accum.sv
// Accumulator registers: count, sum, sum of squares, minimum and maximum.
// Depends on srs_pkg.
module srs_accum #(
	parameter int CW = 17
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  srs_pkg::in_word_t               word,
	output logic [CW-1:0]                   count,
	output logic [srs_pkg::SUM_W-1:0]       sum,
	output logic [srs_pkg::SQ_W-1:0]        sq_sum,
	output logic [srs_pkg::SAMPLE_W-1:0]    min_val,
	output logic [srs_pkg::SAMPLE_W-1:0]    max_val,
	output logic                            full
);

	logic [CW-1:0]                     cnt_q, base_cnt, cnt_d;
	logic [srs_pkg::SUM_W-1:0]         sum_q, base_sum, sum_d;
	logic [srs_pkg::SQ_W-1:0]          sq_q, base_sq, sq_d;
	logic [srs_pkg::SAMPLE_W-1:0]      min_q, base_min, min_d;
	logic [srs_pkg::SAMPLE_W-1:0]      max_q, base_max, max_d;
	logic [2*srs_pkg::SAMPLE_W-1:0]    sq_term;
	logic                              full_q, full_d;

	always_comb begin
		base_cnt = word.restart ? '0 : cnt_q;
		base_sum = word.restart ? '0 : sum_q;
		base_sq  = word.restart ? '0 : sq_q;
		base_min = word.restart ? '1 : min_q;
		base_max = word.restart ? '0 : max_q;
		sq_term  = (2*srs_pkg::SAMPLE_W)'(word.sample) * (2*srs_pkg::SAMPLE_W)'(word.sample);
		full_d   = base_cnt[CW-1];
		cnt_d    = base_cnt;
		sum_d    = base_sum;
		sq_d     = base_sq;
		min_d    = base_min;
		max_d    = base_max;
		if (!full_d) begin
			cnt_d = base_cnt + CW'(1);
			sum_d = base_sum + srs_pkg::SUM_W'(word.sample);
			sq_d  = base_sq + srs_pkg::SQ_W'(sq_term);
			if (word.sample < base_min) begin
				min_d = word.sample;
			end
			if (word.sample > base_max) begin
				max_d = word.sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			min_q  <= '1;
			max_q  <= '0;
			full_q <= 1'b0;
		end else if (take) begin
			cnt_q  <= cnt_d;
			sum_q  <= sum_d;
			sq_q   <= sq_d;
			min_q  <= min_d;
			max_q  <= max_d;
			full_q <= full_d;
		end
	end

	assign count   = cnt_q;
	assign sum     = sum_q;
	assign sq_sum  = sq_q;
	assign min_val = min_q;
	assign max_val = max_q;
	assign full    = full_q;

endmodule

### src/srs_mul.sv
// Serial shift-and-add multiplier, one multiplier bit per cycle while ctl.step is set, MSB first.
// Depends on srs_pkg.
module srs_mul #(
	parameter int M_W = 48,
	parameter int P_W = 65
) (
	input  logic                              clk,
	input  srs_pkg::unit_ctl_t                ctl,
	input  logic [M_W-1:0]                    mcand,
	input  logic [srs_pkg::MUL_STEPS-1:0]     mplier,
	output logic [P_W-1:0]                    product
);

	logic [M_W-1:0]                   mc_q;
	logic [srs_pkg::MUL_STEPS-1:0]    mp_q;
	logic [P_W-1:0]                   acc_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mc_q  <= mcand;
			mp_q  <= mplier;
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0}
				+ P_W'(mp_q[srs_pkg::MUL_STEPS-1] ? mc_q : '0);
			mp_q  <= {mp_q[srs_pkg::MUL_STEPS-2:0], 1'b0};
		end
	end

	assign product = acc_q;

endmodule

### src/srs_div.sv
// Serial restoring divider, one dividend bit in and one quotient bit out per
// cycle while ctl.step is set; the quotient saturates at its width. Depends on srs_pkg.
module srs_div #(
	parameter int DV_W = 17,
	parameter int Q_W  = 20
) (
	input  logic               clk,
	input  srs_pkg::unit_ctl_t ctl,
	input  logic [DV_W-1:0]    divisor,
	input  logic               din,
	output logic [Q_W-1:0]     quotient
);

	logic [DV_W-1:0] dv_q, rem_q;
	logic [Q_W-1:0]  q_q;
	logic            ovf_q;
	logic [DV_W:0]   trial, diff;
	logic            ge;

	always_comb begin
		trial = {rem_q, din};
		diff  = trial - {1'b0, dv_q};
		ge    = trial >= {1'b0, dv_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dv_q  <= divisor;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
			q_q   <= {q_q[Q_W-2:0], ge};
			ovf_q <= ovf_q | q_q[Q_W-1];
		end
	end

	assign quotient = ovf_q ? '1 : q_q;

endmodule

### src/srs_sqrt.sv
// Serial integer square root, two radicand bits in and one root bit out per
// cycle while ctl.step is set. Depends on srs_pkg.
module srs_sqrt #(
	parameter int R_W = 37
) (
	input  logic               clk,
	input  srs_pkg::unit_ctl_t ctl,
	input  logic [2*R_W-1:0]   radicand,
	output logic [R_W-1:0]     root
);

	logic [2*R_W-1:0] x_q;
	logic [R_W+1:0]   rem_q, rem4, trial;
	logic [R_W-1:0]   root_q;
	logic             ge;

	always_comb begin
		rem4  = {rem_q[R_W-1:0], x_q[2*R_W-1 -: 2]};
		trial = {root_q, 2'b01};
		ge    = rem4 >= trial;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.step) begin
			x_q    <= {x_q[2*R_W-3:0], 2'b00};
			rem_q  <= ge ? rem4 - trial : rem4;
			root_q <= {root_q[R_W-2:0], ge};
		end
	end

	assign root = root_q;

endmodule

### src/sample_running_statistics_unit.sv
// Top level of the running statistics unit: accumulators, serial arithmetic
// and the sequencer. Depends on srs_pkg, assert_macros.svh and the srs_ units.
//
// Each accepted sample word updates count, sum, sum of squares, minimum and
// maximum, and one result word follows with count, mean and population standard
// deviation (both with 4 fraction bits), minimum, maximum and spread. After
// acceptance the serial multipliers form n*sumsq and sum*sum, then the square
// root delivers one root bit a cycle while the standard deviation divider
// consumes each bit in the cycle after. The mean divider runs alongside the
// multipliers. No new sample word is accepted until the sequencer is idle
// again. A finished result waits in the output register while the next sample
// is already accepted. Once 2^COUNT_BITS samples are held, further samples are
// ignored and flagged with full_res until a restart.
`include "assert_macros.svh"

module sample_running_statistics_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  srs_pkg::in_word_t  sample_word,
	output logic               result_valid,
	input  logic               result_ready,
	output srs_pkg::out_word_t result_word
);

	localparam int CW         = COUNT_BITS + 1;
	localparam int A_W        = srs_pkg::SQ_W + CW;
	localparam int B_W        = 2 * srs_pkg::SUM_W;
	localparam int CMP_W      = (A_W > B_W) ? A_W : B_W;
	localparam int SQ_STEPS   = (A_W + srs_pkg::SQRT_SHIFT + 1) / 2;
	localparam int STEP_MAX   = (srs_pkg::MUL_STEPS > SQ_STEPS) ? srs_pkg::MUL_STEPS : SQ_STEPS;
	localparam int STEP_W     = $clog2(STEP_MAX + 1);
	localparam int MEAN_CNT_W = $clog2(srs_pkg::MEAN_STEPS + 1);

	srs_pkg::state_t state_q, state_d;
	logic [STEP_W-1:0]     step_q;
	logic [MEAN_CNT_W-1:0] mean_cnt_q;
	logic [srs_pkg::MEAN_STEPS-1:0] mean_x_q;
	logic                  mean_busy;
	logic                  sd_step_s1;
	logic                  fin_go;
	logic                  out_load;
	logic                  result_valid_q;
	srs_pkg::out_word_t    result_word_q;

	srs_pkg::unit_ctl_t mul_ctl, mean_ctl, sq_ctl, sd_ctl;

	logic [CW-1:0]                   acc_cnt;
	logic [srs_pkg::SUM_W-1:0]       acc_sum;
	logic [srs_pkg::SQ_W-1:0]        acc_sq;
	logic [srs_pkg::SAMPLE_W-1:0]    acc_min, acc_max;
	logic                            acc_full;

	logic [A_W-1:0]          prod_a;
	logic [B_W-1:0]          prod_b;
	logic [CMP_W:0]          var_diff;
	logic [A_W-1:0]          var_term;
	logic [2*SQ_STEPS-1:0]   radicand;
	logic [SQ_STEPS-1:0]     root;
	logic [srs_pkg::MEAN_W-1:0] mean_q;
	logic [srs_pkg::STD_W-1:0]  sd_q;

	assign sample_ready = (state_q == srs_pkg::ST_IDLE);
	assign mean_busy    = (mean_cnt_q != '0);
	assign fin_go       = (state_q == srs_pkg::ST_FIN) && !mean_busy && !sd_step_s1
		&& (!result_valid_q || result_ready);

	srs_accum #(.CW(CW)) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (sample_valid && sample_ready),
		.word    (sample_word),
		.count   (acc_cnt),
		.sum     (acc_sum),
		.sq_sum  (acc_sq),
		.min_val (acc_min),
		.max_val (acc_max),
		.full    (acc_full)
	);

	srs_mul #(.M_W(srs_pkg::SQ_W), .P_W(A_W)) u_mul_nsq (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (acc_sq),
		.mplier  (srs_pkg::MUL_STEPS'(acc_cnt)),
		.product (prod_a)
	);

	srs_mul #(.M_W(srs_pkg::SUM_W), .P_W(B_W)) u_mul_sum2 (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (acc_sum),
		.mplier  (acc_sum),
		.product (prod_b)
	);

	srs_div #(.DV_W(CW), .Q_W(srs_pkg::MEAN_W)) u_div_mean (
		.clk      (clk),
		.ctl      (mean_ctl),
		.divisor  (acc_cnt),
		.din      (mean_x_q[srs_pkg::MEAN_STEPS-1]),
		.quotient (mean_q)
	);

	always_comb begin
		var_diff = {1'b0, CMP_W'(prod_a)} - {1'b0, CMP_W'(prod_b)};
		var_term = var_diff[CMP_W] ? '0 : var_diff[A_W-1:0];
		radicand = (2*SQ_STEPS)'({var_term, {srs_pkg::SQRT_SHIFT{1'b0}}});
	end

	srs_sqrt #(.R_W(SQ_STEPS)) u_sqrt (
		.clk      (clk),
		.ctl      (sq_ctl),
		.radicand (radicand),
		.root     (root)
	);

	srs_div #(.DV_W(CW), .Q_W(srs_pkg::STD_W)) u_div_sd (
		.clk      (clk),
		.ctl      (sd_ctl),
		.divisor  (acc_cnt),
		.din      (root[0]),
		.quotient (sd_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = srs_pkg::ST_LOAD;
				end
			end
			srs_pkg::ST_LOAD: begin
				state_d = srs_pkg::ST_MUL;
			end
			srs_pkg::ST_MUL: begin
				if (step_q == STEP_W'(1)) begin
					state_d = srs_pkg::ST_PREP;
				end
			end
			srs_pkg::ST_PREP: begin
				state_d = srs_pkg::ST_ROOT;
			end
			srs_pkg::ST_ROOT: begin
				if (step_q == STEP_W'(1)) begin
					state_d = srs_pkg::ST_FIN;
				end
			end
			srs_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = srs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mul_ctl  = '0;
		sq_ctl   = '0;
		sd_ctl   = '0;
		mean_ctl = '0;
		out_load = 1'b0;
		mean_ctl.step = mean_busy;
		sd_ctl.step   = sd_step_s1;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
			end
			srs_pkg::ST_LOAD: begin
				mul_ctl.load  = 1'b1;
				mean_ctl.load = 1'b1;
			end
			srs_pkg::ST_MUL: begin
				mul_ctl.step = 1'b1;
			end
			srs_pkg::ST_PREP: begin
				sq_ctl.load = 1'b1;
				sd_ctl.load = 1'b1;
			end
			srs_pkg::ST_ROOT: begin
				sq_ctl.step = 1'b1;
			end
			srs_pkg::ST_FIN: begin
				out_load = fin_go;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= srs_pkg::ST_IDLE;
			step_q         <= '0;
			mean_cnt_q     <= '0;
			sd_step_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sd_step_s1 <= sq_ctl.step;
			if (state_q == srs_pkg::ST_LOAD) begin
				step_q <= STEP_W'(srs_pkg::MUL_STEPS);
			end else if (state_q == srs_pkg::ST_PREP) begin
				step_q <= STEP_W'(SQ_STEPS);
			end else if (mul_ctl.step || sq_ctl.step) begin
				step_q <= step_q - STEP_W'(1);
			end
			if (mean_ctl.load) begin
				mean_cnt_q <= MEAN_CNT_W'(srs_pkg::MEAN_STEPS);
			end else if (mean_busy) begin
				mean_cnt_q <= mean_cnt_q - MEAN_CNT_W'(1);
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mean_ctl.load) begin
			mean_x_q <= {acc_sum, {srs_pkg::MEAN_FRAC{1'b0}}};
		end else if (mean_busy) begin
			mean_x_q <= {mean_x_q[srs_pkg::MEAN_STEPS-2:0], 1'b0};
		end
		if (out_load) begin
			result_word_q.sample_count <= srs_pkg::CNT_OUT_W'(acc_cnt);
			result_word_q.mean_q4      <= mean_q;
			result_word_q.std_dev_q4   <= sd_q;
			result_word_q.minimum      <= acc_min;
			result_word_q.maximum      <= acc_max;
			result_word_q.spread       <= acc_max - acc_min;
			result_word_q.full_res     <= acc_full;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_word_q;

	`SRS_ASSERT_NEXT(a_accept_loads, clk, arst_n, sample_valid && sample_ready, state_q == srs_pkg::ST_LOAD)
	`SRS_ASSERT_IMP(a_count_limit, clk, arst_n, acc_cnt[CW-1], acc_cnt[CW-2:0] == '0)
	`SRS_ASSERT_IMP(a_mean_done, clk, arst_n, state_q == srs_pkg::ST_FIN, !mean_busy)
	`SRS_ASSERT_IMP(a_min_le_max, clk, arst_n, state_q == srs_pkg::ST_LOAD, acc_min <= acc_max)
	`SRS_ASSERT_IMP(a_sd_window, clk, arst_n, sd_step_s1, state_q == srs_pkg::ST_ROOT || state_q == srs_pkg::ST_FIN)

endmodule

### bench/stats_checker.sv
`timescale 1ns / 100ps
// Checker for the running statistics unit: watches both word channels, predicts each
// result word from the accepted sample words and compares each whole word with it.
// Depends on srs_pkg for the word types and field widths.
module stats_checker #(
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_ready,
	input  srs_pkg::in_word_t  sample_word,
	input  logic               result_valid,
	input  logic               result_ready,
	input  srs_pkg::out_word_t result_word,
	output int                 mismatch_count,
	output int                 expected_left
);

	localparam logic [COUNT_BITS:0]          HELD_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};
	localparam logic [srs_pkg::MEAN_W-1:0]   MEAN_TOP   = '1;
	localparam logic [srs_pkg::STD_W-1:0]    STD_TOP    = '1;

	logic [srs_pkg::SUM_W-1:0]    acc_sum;
	logic [srs_pkg::SQ_W-1:0]     acc_sq;
	logic [COUNT_BITS:0]          held;
	logic [srs_pkg::SAMPLE_W-1:0] lo_seen;
	logic [srs_pkg::SAMPLE_W-1:0] hi_seen;
	srs_pkg::out_word_t           stats_due[$];
	int                           mism = 0;

	function automatic void clear_stats();
		acc_sum = '0;
		acc_sq  = '0;
		held    = '0;
		lo_seen = '1;
		hi_seen = '0;
	endfunction

	function automatic srs_pkg::out_word_t advance_stats(srs_pkg::in_word_t w);
		srs_pkg::out_word_t r;
		logic [127:0] n_sq;
		logic [127:0] sum_sq;
		logic [127:0] radicand;
		logic [63:0]  n_wide;
		logic [63:0]  quot;
		logic [63:0]  root;
		logic [63:0]  trial;
		if (w.restart) begin
			clear_stats();
		end
		r = '0;
		r.full_res = (held >= HELD_LIMIT);
		if (!r.full_res) begin
			acc_sum = acc_sum + srs_pkg::SUM_W'(w.sample);
			acc_sq  = acc_sq + srs_pkg::SQ_W'(w.sample) * srs_pkg::SQ_W'(w.sample);
			held    = held + 1'b1;
			if (w.sample > hi_seen) begin
				hi_seen = w.sample;
			end
			if (w.sample < lo_seen) begin
				lo_seen = w.sample;
			end
		end
		n_wide = 64'(held);
		if (held != '0) begin
			quot = {28'd0, acc_sum, 4'd0} / n_wide;
			r.mean_q4 = (quot > 64'(MEAN_TOP)) ? MEAN_TOP : quot[srs_pkg::MEAN_W-1:0];
			n_sq   = 128'(n_wide) * 128'(acc_sq);
			sum_sq = 128'(acc_sum) * 128'(acc_sum);
			if (sum_sq <= n_sq) begin
				radicand = (n_sq - sum_sq) << srs_pkg::SQRT_SHIFT;
				root = '0;
				for (int b = 63; b >= 0; b--) begin
					trial = root | (64'd1 << b);
					if (128'(trial) * 128'(trial) <= radicand) begin
						root = trial;
					end
				end
				quot = root / n_wide;
				r.std_dev_q4 = (quot > 64'(STD_TOP)) ? STD_TOP : quot[srs_pkg::STD_W-1:0];
			end
		end
		r.sample_count = srs_pkg::CNT_OUT_W'(held);
		r.minimum      = lo_seen;
		r.maximum      = hi_seen;
		r.spread       = hi_seen - lo_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		srs_pkg::out_word_t want;
		if (!arst_n) begin
			clear_stats();
			stats_due.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (stats_due.size() == 0) begin
					mism++;
					if (mism <= 10) begin
						$display("unexpected result word: count=%0d mean=%0d sd=%0d",
							result_word.sample_count, result_word.mean_q4,
							result_word.std_dev_q4);
					end
				end else begin
					want = stats_due.pop_front();
					if (result_word !== want) begin
						mism++;
						if (mism <= 10) begin
							$display("mismatch: expected count=%0d mean=%0d sd=%0d min=%0d max=%0d spread=%0d full=%0d",
								want.sample_count, want.mean_q4, want.std_dev_q4,
								want.minimum, want.maximum, want.spread, want.full_res);
							$display("          got      count=%0d mean=%0d sd=%0d min=%0d max=%0d spread=%0d full=%0d",
								result_word.sample_count, result_word.mean_q4,
								result_word.std_dev_q4, result_word.minimum,
								result_word.maximum, result_word.spread,
								result_word.full_res);
						end
					end
				end
			end
			if (sample_valid && sample_ready) begin
				stats_due.push_back(advance_stats(sample_word));
			end
		end
		mismatch_count <= mism;
		expected_left  <= stats_due.size();
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the running statistics regression: clock, reset, sample word stimulus and
// result flow control; the checking is done by stats_checker beside the unit.
// Depends on srs_pkg, stats_checker and sample_running_statistics_unit.
module testbench;

	localparam int COUNT_BITS       = 16;
	localparam int RANDOM_PER_PHASE = 445;
	localparam int CYCLE_LIMIT      = 2000000;

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_ready;
	srs_pkg::in_word_t  sample_word;
	logic               result_valid;
	logic               result_ready;
	srs_pkg::out_word_t result_word;
	int                 mismatch_count;
	int                 expected_left;
	int                 idle_pct;
	int                 stall_pct;
	logic               hold_off;
	int                 words_sent;
	int                 cycle_count;

	sample_running_statistics_unit #(
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_word(sample_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_word(result_word)
	);

	stats_checker #(
		.COUNT_BITS(COUNT_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_word(sample_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_word(result_word),
		.mismatch_count(mismatch_count),
		.expected_left(expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sample_running_statistics_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// The result side holds off long enough for the unit to fill and stall its input.
	initial begin
		hold_off <= 1'b0;
		wait (words_sent >= 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (800) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic offer_word(input logic [srs_pkg::SAMPLE_W-1:0] value, input logic restart);
		srs_pkg::in_word_t w;
		w.sample  = value;
		w.restart = restart;
		if ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		words_sent++;
	endtask

	function automatic logic [srs_pkg::SAMPLE_W-1:0] pick_sample(int mode,
		logic [srs_pkg::SAMPLE_W-1:0] center);
		unique case (mode)
			0: begin
				return srs_pkg::SAMPLE_W'($urandom_range(0, 65535));
			end
			1: begin
				return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			end
			2: begin
				return center;
			end
			3: begin
				return center ^ srs_pkg::SAMPLE_W'($urandom_range(0, 255));
			end
			4: begin
				return srs_pkg::SAMPLE_W'($urandom_range(0, 15));
			end
			default: begin
				return 16'hffff - srs_pkg::SAMPLE_W'($urandom_range(0, 15));
			end
		endcase
	endfunction

	initial begin
		int                           phase_idle[4];
		int                           phase_stall[4];
		int                           phase_start;
		int                           run_len;
		int                           mode;
		logic [srs_pkg::SAMPLE_W-1:0] center;
		phase_idle  = '{0, 61, 0, 27};
		phase_stall = '{0, 0, 61, 27};
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample_word  <= '0;
		idle_pct     <= 0;
		stall_pct    <= 0;
		words_sent   = 0;
		cycle_count  <= 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_word(16'd1234, 1'b0);
		offer_word(16'h0000, 1'b1);
		offer_word(16'hffff, 1'b0);
		offer_word(16'hffff, 1'b1);
		offer_word(16'hffff, 1'b0);
		offer_word(16'h0000, 1'b1);
		offer_word(16'h0000, 1'b0);
		// A run of sixteen words after a restart, both extremes, then another restart.
		offer_word(16'h8000, 1'b1);
		for (int i = 1; i < 16; i++) begin
			offer_word(srs_pkg::SAMPLE_W'(i * 16'h1111), 1'b0);
		end
		offer_word(16'h0000, 1'b0);
		offer_word(16'hffff, 1'b0);
		offer_word(16'h1234, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct    <= phase_idle[ph];
			stall_pct   <= phase_stall[ph];
			phase_start = words_sent;
			while (words_sent - phase_start < RANDOM_PER_PHASE) begin
				if ($urandom_range(99) < 8) begin
					offer_word(srs_pkg::SAMPLE_W'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
				end else begin
					run_len = ($urandom_range(99) < 70) ? $urandom_range(1, 12)
						: $urandom_range(13, 24);
					mode   = $urandom_range(0, 5);
					center = srs_pkg::SAMPLE_W'($urandom_range(0, 65535));
					for (int k = 0; k < run_len; k++) begin
						offer_word(pick_sample(mode, center),
							(k == 0) && ($urandom_range(99) < 90));
					end
				end
			end
		end
		sample_valid <= 1'b0;

		while (expected_left != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_left == 0) begin
			$display("sample_running_statistics_unit regression: pass");
		end else begin
			$display("sample_running_statistics_unit regression: fail");
		end
		$finish;
	end

endmodule

### sample_running_statistics_unit.f
+incdir+src
src/srs_pkg.sv
src/srs_accum.sv
src/srs_mul.sv
src/srs_div.sv
src/srs_sqrt.sv
src/sample_running_statistics_unit.sv
bench/stats_checker.sv
bench/testbench.sv
